### src/hmd_pkg.sv
// ----------------------------------------------------------------------------
// hmd_pkg
// types, constants and the hamming(7,4) nibble decoder shared by the deframer
// ----------------------------------------------------------------------------
package hmd_pkg;

    localparam int WIN_LEN = 6;
    localparam int FILL_W  = 3;
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WIN_LEN - 1);

    typedef struct packed {
        logic       fixed;
        logic [3:0] nib;
    } nib_t;

    typedef struct packed {
        logic [7:0] pkt_type;
        logic [7:0] pkt_data;
        logic       fixed;
    } pkt_t;

    // codeword bit to flip for each nonzero syndrome
    function automatic logic [6:0] flip_mask(input logic [2:0] syn);
        logic [6:0] m;
        case (syn)
            3'd1:    m = 7'h08;
            3'd2:    m = 7'h20;
            3'd3:    m = 7'h02;
            3'd4:    m = 7'h40;
            3'd5:    m = 7'h04;
            3'd6:    m = 7'h10;
            3'd7:    m = 7'h01;
            default: m = 7'h00;
        endcase
        return m;
    endfunction

    // layout p1 p2 d1 p3 d2 d3 d4 from bit 6 down, bit 7 ignored
    function automatic nib_t hamming_decode(input logic [7:0] code);
        logic [6:0] b;
        logic [2:0] syn;
        nib_t       r;
        b      = code[6:0];
        syn[2] = b[6] ^ b[4] ^ b[2] ^ b[0];
        syn[1] = b[5] ^ b[4] ^ b[1] ^ b[0];
        syn[0] = b[3] ^ b[2] ^ b[1] ^ b[0];
        b      = b ^ flip_mask(syn);
        r.fixed = (syn != 3'd0);
        r.nib   = {b[4], b[2], b[1], b[0]};
        return r;
    endfunction

endpackage

### src/hmd_front.sv
// ----------------------------------------------------------------------------
// hmd_front
// byte window, six parallel nibble decoders and the packet check
// ----------------------------------------------------------------------------
module hmd_front
    import hmd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       push_valid,
    output pkt_t       push_pkt,
    input  logic       push_ready
);

    logic [7:0]        window_reg  [WIN_LEN];
    logic [7:0]        window_next [WIN_LEN];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [7:0]        frame [WIN_LEN];
    nib_t              dec   [WIN_LEN];
    logic              any_fixed;
    logic              match;
    logic              accept;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    // full frame as seen with the incoming byte in the last slot
    always_comb begin
        any_fixed = 1'b0;
        for (int i = 0; i < WIN_LEN; i++) begin
            frame[i] = (i == WIN_LEN - 1) ? s_rx_byte : window_reg[i];
            dec[i]   = hamming_decode(frame[i]);
            any_fixed = any_fixed | dec[i].fixed;
        end
        push_pkt.pkt_type = {dec[0].nib, dec[1].nib};
        push_pkt.pkt_data = {dec[2].nib, dec[3].nib};
        push_pkt.fixed    = any_fixed;
        match = ((push_pkt.pkt_type ^ push_pkt.pkt_data) == {dec[4].nib, dec[5].nib});
    end

    assign push_valid = accept && (fill_reg == FILL_LAST) && match;

    always_comb begin
        window_next = window_reg;
        fill_next   = fill_reg;
        if (accept) begin
            if (fill_reg == FILL_LAST) begin
                if (match) begin
                    fill_next = '0;
                end else begin
                    for (int i = 0; i < WIN_LEN - 2; i++) begin
                        window_next[i] = window_reg[i+1];
                    end
                    window_next[WIN_LEN-2] = s_rx_byte;
                    fill_next = FILL_LAST;
                end
            end else begin
                window_next[fill_reg] = s_rx_byte;
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        window_reg <= window_next;
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

endmodule

### src/hmd_fifo.sv
// ----------------------------------------------------------------------------
// hmd_fifo
// short packet queue between the decode front and the output back
// ----------------------------------------------------------------------------
module hmd_fifo
    import hmd_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    input  pkt_t push_pkt,
    output logic push_ready,
    output logic pop_valid,
    output pkt_t pop_pkt,
    input  logic pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pkt_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_pkt    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_pkt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/hmd_back.sv
// ----------------------------------------------------------------------------
// hmd_back
// corrected-packet counter and registered output stage
// ----------------------------------------------------------------------------
module hmd_back
    import hmd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        pop_valid,
    input  pkt_t        pop_pkt,
    output logic        pop_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pkt_type,
    output logic [7:0]  m_pkt_data,
    output logic        m_had_correction,
    output logic [31:0] m_corrected_total
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] count_reg;
    logic [31:0] count_next;
    logic [7:0]  type_reg;
    logic [7:0]  data_reg;
    logic        fixed_reg;
    logic        load;

    assign pop_ready = !valid_reg || m_ready;
    assign load      = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        valid_next = valid_reg;
        if (load) begin
            count_next = count_reg + {31'd0, pop_pkt.fixed};
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            type_reg  <= pop_pkt.pkt_type;
            data_reg  <= pop_pkt.pkt_data;
            fixed_reg <= pop_pkt.fixed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    assign m_valid           = valid_reg;
    assign m_pkt_type        = type_reg;
    assign m_pkt_data        = data_reg;
    assign m_had_correction  = fixed_reg;
    assign m_corrected_total = count_reg;

endmodule

### src/hamming74_packet_deframer.sv
// ----------------------------------------------------------------------------
// hamming74_packet_deframer
// hamming(7,4) decoder with sliding frame sync over a six-byte window
// ----------------------------------------------------------------------------
// input channel s_: one received serial byte per transaction. the byte joins
// a six-byte window; once six are held, every byte is decoded as a (7,4)
// codeword and type, data and check bytes are formed. a good check yields
// one output transaction and empties the window, a bad one drops the oldest
// byte.
// output channel m_: type, data, a correction flag and the running count of
// corrected packets, which wraps at 2^32.
// throughput: one byte per cycle while the packet queue has room, since the
// window decode is combinational. a packet's last byte is decoded into the
// queue when taken, then the packet passes the output register to m_.
// a packet queue of FIFO_DEPTH entries sits between decode and output; when
// m_ready stays low it fills and s_ready drops, so nothing is lost.
// reset: window emptied, counter cleared, queue and output register empty.
// ----------------------------------------------------------------------------
module hamming74_packet_deframer
    import hmd_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pkt_type,
    output logic [7:0]  m_pkt_data,
    output logic        m_had_correction,
    output logic [31:0] m_corrected_total
);

    logic push_valid;
    pkt_t push_pkt;
    logic push_ready;
    logic pop_valid;
    pkt_t pop_pkt;
    logic pop_ready;

    hmd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .push_valid (push_valid),
        .push_pkt   (push_pkt),
        .push_ready (push_ready)
    );

    hmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_pkt   (push_pkt),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_pkt    (pop_pkt),
        .pop_ready  (pop_ready)
    );

    hmd_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .pop_valid         (pop_valid),
        .pop_pkt           (pop_pkt),
        .pop_ready         (pop_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pkt_type        (m_pkt_type),
        .m_pkt_data        (m_pkt_data),
        .m_had_correction  (m_had_correction),
        .m_corrected_total (m_corrected_total)
    );

endmodule

### verif/tb_hamming74_packet_deframer.sv
// ----------------------------------------------------------------------------
// tb_hamming74_packet_deframer
// self-checking bench for the hamming(7,4) packet deframer
// ----------------------------------------------------------------------------
// bytes are fed through the s_ channel and mirrored into a scoreboard that
// keeps its own six-byte window, decodes it with single-bit correction and
// queues the packet expected on m_. a short directed run covers clean frames,
// all-ones and all-zeros codewords, single and double bit errors and lost sync;
// the random run is mostly encoded frames, some with injected errors, mixed
// with noise bytes and truncated frames. the sender idles in bursts, the
// receiver stalls on its own pattern, holds off once for a long stretch and
// the sender drains once mid-run.
// ----------------------------------------------------------------------------
module tb_hamming74_packet_deframer;

    localparam int TOTAL_BYTES = 1175;
    localparam int LONG_HOLD   = 400;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0]  ptype;
        logic [7:0]  pdata;
        logic        corr;
        logic [31:0] total;
    } packet_exp_t;

    typedef enum {TOP_CLEAR, TOP_SET, TOP_RAND} top_mode_t;
    typedef enum {RX_ALWAYS, RX_COIN, RX_SLOW, RX_TOGGLE} rx_mode_t;

    class deframe_scoreboard;
        logic [7:0]  win [hmd_pkg::WIN_LEN];
        int          fill;
        logic [31:0] corr_packets;
        packet_exp_t expected_packets [$];
        int          bad_count;

        function new();
            foreach (win[i]) win[i] = 8'h00;
            fill         = 0;
            corr_packets = 32'd0;
            bad_count    = 0;
        endfunction

        // syndrome read as {s3,s2,s1} is the failing position, bit 6 is position 1
        function logic [3:0] decode_codeword(input logic [7:0] code, inout bit corr);
            logic [6:0] cw;
            logic [2:0] pos;
            cw     = code[6:0];
            pos[0] = cw[6] ^ cw[4] ^ cw[2] ^ cw[0];
            pos[1] = cw[5] ^ cw[4] ^ cw[1] ^ cw[0];
            pos[2] = cw[3] ^ cw[2] ^ cw[1] ^ cw[0];
            if (pos != 3'd0) begin
                cw[7 - int'(pos)] = ~cw[7 - int'(pos)];
                corr = 1'b1;
            end
            return {cw[4], cw[2], cw[1], cw[0]};
        endfunction

        function void take_byte(input logic [7:0] b);
            logic [7:0]  dec [3];
            bit          corr;
            packet_exp_t e;
            if (fill >= hmd_pkg::WIN_LEN)
                fill = hmd_pkg::WIN_LEN - 1;
            win[fill] = b;
            fill++;
            if (fill < hmd_pkg::WIN_LEN)
                return;
            corr = 1'b0;
            for (int i = 0; i < 3; i++)
                dec[i] = {decode_codeword(win[2*i], corr), decode_codeword(win[2*i+1], corr)};
            if ((dec[0] ^ dec[1]) == dec[2]) begin
                if (corr)
                    corr_packets = corr_packets + 32'd1;
                fill    = 0;
                e.ptype = dec[0];
                e.pdata = dec[1];
                e.corr  = corr;
                e.total = corr_packets;
                expected_packets.push_back(e);
            end else begin
                for (int i = 0; i + 1 < hmd_pkg::WIN_LEN; i++)
                    win[i] = win[i+1];
                fill = hmd_pkg::WIN_LEN - 1;
            end
        endfunction

        function void check_packet(input logic [7:0] ptype, input logic [7:0] pdata,
                                   input logic corr, input logic [31:0] total);
            packet_exp_t want;
            if (expected_packets.size() == 0) begin
                bad_count++;
                if (bad_count <= MAX_REPORTS)
                    $display("%0t: unexpected packet type %02h data %02h corr %0d total %0d",
                             $time, ptype, pdata, corr, total);
                return;
            end
            want = expected_packets.pop_front();
            if (ptype !== want.ptype || pdata !== want.pdata ||
                corr !== want.corr || total !== want.total) begin
                bad_count++;
                if (bad_count <= MAX_REPORTS)
                    $display("%0t: packet mismatch exp type %02h data %02h corr %0d total %0d, got type %02h data %02h corr %0d total %0d",
                             $time, want.ptype, want.pdata, want.corr, want.total,
                             ptype, pdata, corr, total);
            end
        endfunction
    endclass

    logic        aclk              = 1'b0;
    logic        aresetn           = 1'b0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte         = 8'h00;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic [7:0]  m_pkt_type;
    logic [7:0]  m_pkt_data;
    logic        m_had_correction;
    logic [31:0] m_corrected_total;

    deframe_scoreboard board = new();

    int       bytes_sent  = 0;
    int       burst_left  = 0;
    int       hold_asked  = 0;
    int       hold_given  = 0;
    int       hold_left   = 0;
    int       phase_left  = 0;
    rx_mode_t rx_mode     = RX_ALWAYS;

    hamming74_packet_deframer DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pkt_type        (m_pkt_type),
        .m_pkt_data        (m_pkt_data),
        .m_had_correction  (m_had_correction),
        .m_corrected_total (m_corrected_total)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [6:0] encode_nibble(input logic [3:0] n);
        return {n[3] ^ n[2] ^ n[0], n[3] ^ n[1] ^ n[0], n[3],
                n[2] ^ n[1] ^ n[0], n[2], n[1], n[0]};
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(1, 12);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        board.take_byte(b);
        bytes_sent++;
        burst_left--;
    endtask

    // flips land in random bytes, or in distinct bits of one byte
    task automatic send_packet(input logic [7:0] ptype, input logic [7:0] pdata,
                               input int flips, input bit one_byte, input int keep,
                               input top_mode_t top);
        logic [7:0] frame [6];
        logic [7:0] chk;
        logic [6:0] used;
        int         victim;
        int         bitpos;
        chk      = ptype ^ pdata;
        frame[0] = {1'b0, encode_nibble(ptype[7:4])};
        frame[1] = {1'b0, encode_nibble(ptype[3:0])};
        frame[2] = {1'b0, encode_nibble(pdata[7:4])};
        frame[3] = {1'b0, encode_nibble(pdata[3:0])};
        frame[4] = {1'b0, encode_nibble(chk[7:4])};
        frame[5] = {1'b0, encode_nibble(chk[3:0])};
        foreach (frame[i]) begin
            case (top)
                TOP_CLEAR: frame[i][7] = 1'b0;
                TOP_SET:   frame[i][7] = 1'b1;
                default:   frame[i][7] = 1'($urandom_range(0, 1));
            endcase
        end
        used   = 7'd0;
        victim = $urandom_range(0, 5);
        for (int k = 0; k < flips; k++) begin
            if (!one_byte)
                victim = $urandom_range(0, 5);
            do bitpos = $urandom_range(0, 6); while (one_byte && used[bitpos]);
            used[bitpos] = 1'b1;
            frame[victim][bitpos] = ~frame[victim][bitpos];
        end
        for (int i = 0; i < keep; i++)
            send_byte(frame[i]);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (board.expected_packets.size() != 0) @(posedge aclk);
        burst_left = 0;
    endtask

    // output side: check on handshake, then pick the next ready value
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_packet(m_pkt_type, m_pkt_data, m_had_correction, m_corrected_total);
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_asked != hold_given) begin
            hold_given++;
            hold_left = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                rx_mode    = rx_mode_t'($urandom_range(0, 3));
                phase_left = $urandom_range(20, 150);
            end
            phase_left--;
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SLOW:   m_ready <= ($urandom_range(0, 4) == 0);
                default:   m_ready <= ~m_ready;
            endcase
        end
    end

    initial begin
        int pick;
        int flips;
        bit drained;
        drained = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all-ones and all-zeros codewords
        send_packet(8'hFF, 8'hFF, 0, 1'b0, 6, TOP_SET);
        // one stray byte ahead of a frame with a single error
        send_byte(8'h3C);
        send_packet(8'h00, 8'h00, 1, 1'b0, 6, TOP_CLEAR);
        // double error in one codeword gets miscorrected
        send_packet(8'hA5, 8'h3C, 2, 1'b1, 6, TOP_RAND);
        send_packet(8'h5A, 8'hC3, 1, 1'b0, 6, TOP_RAND);

        // dense sending while the output holds off
        burst_left = 200;
        hold_asked++;
        while (bytes_sent < TOTAL_BYTES) begin
            if (!drained && bytes_sent >= TOTAL_BYTES / 2) begin
                wait_for_drain();
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                pick  = $urandom_range(0, 9);
                flips = (pick < 6) ? 0 : (pick < 9) ? 1 : 2;
                send_packet(8'($urandom), 8'($urandom), flips, 1'($urandom_range(0, 1)),
                            6, TOP_RAND);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else begin
                send_packet(8'($urandom), 8'($urandom), $urandom_range(0, 1), 1'b0,
                            $urandom_range(1, 5), TOP_RAND);
            end
        end

        wait_for_drain();
        repeat (20) @(posedge aclk);
        if (board.bad_count == 0 && board.expected_packets.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
